### hdl/pea_pkg.sv
`default_nettype none
package pea_pkg;

    // Table geometry
    localparam int MAX_EXTENTS = 64;
    localparam int IDX_W       = $clog2(MAX_EXTENTS);
    localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);

    // Field widths
    localparam int PAGE_W = 20;
    localparam int END_W  = PAGE_W + 1;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 3;
    localparam int OP_W   = 3;

    // One past the last page
    localparam logic [END_W-1:0] PAGE_SPACE = END_W'(21'h100000);

    // Actions
    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_OVERLAP = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL    = 3'd3;
    localparam logic [STAT_W-1:0] STAT_ZERO    = 3'd4;

    // Cell commands
    localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd1; // cell 0 takes start/length
    localparam logic [OP_W-1:0] OP_TAKE   = 3'd2; // cell 0 gives its first page
    localparam logic [OP_W-1:0] OP_DROP   = 3'd3; // cells from idx shift down
    localparam logic [OP_W-1:0] OP_INSERT = 3'd4; // cells above idx shift up
    localparam logic [OP_W-1:0] OP_GROW   = 3'd5; // extend extent idx upwards
    localparam logic [OP_W-1:0] OP_EXTDN  = 3'd6; // extend extent idx downwards
    localparam logic [OP_W-1:0] OP_JOIN   = 3'd7; // absorb page and upper neighbour

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [PAGE_W-1:0] free_page;
    } in_word_t;

    typedef struct packed {
        logic [PAGE_W-1:0] granted_page;
        logic [STAT_W-1:0] status;
        logic [PAGE_W-1:0] pages_free;
    } out_word_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
        logic [PAGE_W-1:0] start;
        logic [PAGE_W-1:0] len;
    } cell_cmd_t;

    typedef struct packed {
        logic valid;   // cell holds a live extent
        logic lt;      // start below page
        logic end_eq;  // extent ends just at page
        logic end_gt;  // extent covers page
        logic st_eq;   // extent starts at page
        logic st_nx;   // extent starts one above page
    } cell_flags_t;

endpackage
`default_nettype wire

### hdl/pea_cell.sv
`default_nettype none
module pea_cell (
    input  wire logic                        aclk,
    input  wire logic [pea_pkg::IDX_W-1:0]   cell_index,
    input  wire logic [pea_pkg::CNT_W-1:0]   count,
    input  wire logic [pea_pkg::PAGE_W-1:0]  page,
    input  wire logic                        cmp_en,
    input  wire pea_pkg::cell_cmd_t          cmd,
    input  wire logic [pea_pkg::PAGE_W-1:0]  left_start,
    input  wire logic [pea_pkg::PAGE_W-1:0]  left_len,
    input  wire logic [pea_pkg::PAGE_W-1:0]  right_start,
    input  wire logic [pea_pkg::PAGE_W-1:0]  right_len,
    output logic [pea_pkg::PAGE_W-1:0]       start_o,
    output logic [pea_pkg::PAGE_W-1:0]       len_o,
    output pea_pkg::cell_flags_t             flags_o
);

    logic [pea_pkg::PAGE_W-1:0] start_reg, start_next;
    logic [pea_pkg::PAGE_W-1:0] len_reg, len_next;
    pea_pkg::cell_flags_t       flags_reg, flags_next;
    logic [pea_pkg::END_W-1:0]  end_w;
    logic [pea_pkg::END_W-1:0]  page_w;
    logic                       here, above;

    assign end_w  = {1'b0, start_reg} + {1'b0, len_reg};
    assign page_w = {1'b0, page};
    assign here   = (cell_index == cmd.idx);
    assign above  = (cell_index > cmd.idx);

    // Local compare against the page being freed
    always_comb begin
        flags_next.valid  = pea_pkg::CNT_W'(cell_index) < count;
        flags_next.lt     = flags_next.valid && (start_reg < page);
        flags_next.end_eq = (end_w == page_w);
        flags_next.end_gt = (end_w > page_w);
        flags_next.st_eq  = (start_reg == page);
        flags_next.st_nx  = ({1'b0, start_reg} == page_w + pea_pkg::END_W'(1));
    end

    // Command from the controller; neighbours hand over their extents
    always_comb begin
        start_next = start_reg;
        len_next   = len_reg;
        case (cmd.op)
            pea_pkg::OP_LOAD: begin
                if (cell_index == '0) begin
                    start_next = cmd.start;
                    len_next   = cmd.len;
                end
            end
            pea_pkg::OP_TAKE: begin
                if (cell_index == '0) begin
                    start_next = start_reg + pea_pkg::PAGE_W'(1);
                    len_next   = len_reg - pea_pkg::PAGE_W'(1);
                end
            end
            pea_pkg::OP_DROP: begin
                if (here || above) begin
                    start_next = right_start;
                    len_next   = right_len;
                end
            end
            pea_pkg::OP_INSERT: begin
                if (here) begin
                    start_next = cmd.start;
                    len_next   = pea_pkg::PAGE_W'(1);
                end else if (above) begin
                    start_next = left_start;
                    len_next   = left_len;
                end
            end
            pea_pkg::OP_GROW: begin
                if (here) len_next = len_reg + pea_pkg::PAGE_W'(1);
            end
            pea_pkg::OP_EXTDN: begin
                if (here) begin
                    start_next = cmd.start;
                    len_next   = len_reg + pea_pkg::PAGE_W'(1);
                end
            end
            pea_pkg::OP_JOIN: begin
                if (here) begin
                    len_next = len_reg + right_len + pea_pkg::PAGE_W'(1);
                end else if (above) begin
                    start_next = right_start;
                    len_next   = right_len;
                end
            end
            default: begin
                start_next = start_reg;
                len_next   = len_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        start_reg <= start_next;
        len_reg   <= len_next;
        if (cmp_en) flags_reg <= flags_next;
    end

    assign start_o = start_reg;
    assign len_o   = len_reg;
    assign flags_o = flags_reg;

endmodule
`default_nettype wire

### hdl/page_extent_allocator_unit.sv
`default_nettype none
// Channel  | Dir | Handshake          | Word
// s_       | in  | s_valid / s_ready  | action, free_page
// m_       | out | m_valid / m_ready  | granted_page, status, pages_free
// cfg_     | in  | cfg_we             | region_base_page (0), region_page_count (1)
//
// Each action passes through the accepting state, compare in every cell, decide,
// then apply one shift or update along the row of cells. The result word is
// registered when the apply step fires; the next word is accepted only after that.
// One action is in flight at a time; s_ready is high only while idle.
// The apply step waits while the output register still holds an untaken word.
// Reset (aresetn low, synchronous) empties the table and zeroes the total.
module page_extent_allocator_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire pea_pkg::in_word_t           s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output pea_pkg::out_word_t               m_data,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [pea_pkg::PAGE_W-1:0]  cfg_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMP   = 2'd1;
    localparam logic [1:0] S_DEC   = 2'd2;
    localparam logic [1:0] S_APPLY = 2'd3;

    localparam int N = pea_pkg::MAX_EXTENTS;

    logic [1:0]                   state_reg, state_next;
    pea_pkg::in_word_t            item_reg;
    logic [pea_pkg::PAGE_W-1:0]   base_reg, pcount_reg;
    logic [pea_pkg::CNT_W-1:0]    count_reg, count_next, dcount_reg;
    logic [pea_pkg::PAGE_W-1:0]   total_reg, total_next, dtotal_reg;
    pea_pkg::cell_cmd_t           cmd_reg, cmd_next, cmd_live;
    pea_pkg::out_word_t           res_reg, res_next, out_reg;
    logic                         m_valid_reg;
    logic                         apply_fire;

    logic [pea_pkg::PAGE_W-1:0]   st_pad  [0:N+1];
    logic [pea_pkg::PAGE_W-1:0]   len_pad [0:N+1];
    pea_pkg::cell_flags_t         flg     [0:N-1];

    logic [N-1:0]                 prev_hit, next_hit;
    logic [pea_pkg::IDX_W-1:0]    prev_idx, next_idx;
    logic                         overlap, join_p, join_n, has_next;
    logic [pea_pkg::END_W-1:0]    space;
    logic [pea_pkg::PAGE_W-1:0]   load_len;

    assign s_ready    = (state_reg == S_IDLE);
    assign apply_fire = (state_reg == S_APPLY) && (!m_valid_reg || m_ready);

    // Row of cells, padded with empty neighbours at both ends
    assign st_pad[0]    = '0;
    assign len_pad[0]   = '0;
    assign st_pad[N+1]  = '0;
    assign len_pad[N+1] = '0;

    always_comb begin
        cmd_live = cmd_reg;
        if (!apply_fire) cmd_live.op = pea_pkg::OP_NOP;
    end

    for (genvar i = 0; i < N; i++) begin : g_cell
        pea_cell u_cell (
            .aclk        (aclk),
            .cell_index  (pea_pkg::IDX_W'(i)),
            .count       (count_reg),
            .page        (item_reg.free_page),
            .cmp_en      (state_reg == S_CMP),
            .cmd         (cmd_live),
            .left_start  (st_pad[i]),
            .left_len    (len_pad[i]),
            .right_start (st_pad[i+2]),
            .right_len   (len_pad[i+2]),
            .start_o     (st_pad[i+1]),
            .len_o       (len_pad[i+1]),
            .flags_o     (flg[i])
        );
    end

    // Locate the extents just below and just above the page
    always_comb begin
        prev_idx = '0;
        next_idx = '0;
        overlap  = 1'b0;
        join_p   = 1'b0;
        join_n   = 1'b0;
        for (int i = 0; i < N; i++) begin
            prev_hit[i] = flg[i].lt && ((i == N-1) ? 1'b1 : !flg[(i+1)%N].lt);
            next_hit[i] = flg[i].valid && !flg[i].lt &&
                          ((i == 0) ? 1'b1 : flg[(i+N-1)%N].lt);
            if (prev_hit[i]) prev_idx = prev_idx | pea_pkg::IDX_W'(i);
            if (next_hit[i]) next_idx = next_idx | pea_pkg::IDX_W'(i);
            overlap = overlap | (prev_hit[i] & flg[i].end_gt) | (next_hit[i] & flg[i].st_eq);
            join_p  = join_p | (prev_hit[i] & flg[i].end_eq);
            join_n  = join_n | (next_hit[i] & flg[i].st_nx);
        end
        has_next = |next_hit;
    end

    // Restart region, clipped to the page space
    always_comb begin
        space    = pea_pkg::PAGE_SPACE - {1'b0, base_reg};
        load_len = ({1'b0, pcount_reg} > space) ? space[pea_pkg::PAGE_W-1:0] : pcount_reg;
    end

    // Decision for the held action
    always_comb begin
        cmd_next       = '0;
        cmd_next.op    = pea_pkg::OP_NOP;
        cmd_next.start = item_reg.free_page;
        res_next       = '0;
        res_next.status = pea_pkg::STAT_OK;
        count_next     = count_reg;
        total_next     = total_reg;
        case (item_reg.action)
            pea_pkg::ACT_ALLOC: begin
                if (total_reg == '0 || count_reg == '0) begin
                    res_next.status = pea_pkg::STAT_EMPTY;
                end else begin
                    res_next.granted_page = st_pad[1];
                    total_next = total_reg - pea_pkg::PAGE_W'(1);
                    if (len_pad[1] == pea_pkg::PAGE_W'(1)) begin
                        cmd_next.op = pea_pkg::OP_DROP;
                        count_next  = count_reg - pea_pkg::CNT_W'(1);
                    end else begin
                        cmd_next.op = pea_pkg::OP_TAKE;
                    end
                end
            end
            pea_pkg::ACT_FREE: begin
                if (item_reg.free_page == '0) begin
                    res_next.status = pea_pkg::STAT_ZERO;
                end else if (overlap) begin
                    res_next.status = pea_pkg::STAT_OVERLAP;
                end else if (join_p && join_n) begin
                    cmd_next.op  = pea_pkg::OP_JOIN;
                    cmd_next.idx = prev_idx;
                    count_next   = count_reg - pea_pkg::CNT_W'(1);
                    total_next   = total_reg + pea_pkg::PAGE_W'(1);
                end else if (join_n) begin
                    cmd_next.op  = pea_pkg::OP_EXTDN;
                    cmd_next.idx = next_idx;
                    total_next   = total_reg + pea_pkg::PAGE_W'(1);
                end else if (join_p) begin
                    cmd_next.op  = pea_pkg::OP_GROW;
                    cmd_next.idx = prev_idx;
                    total_next   = total_reg + pea_pkg::PAGE_W'(1);
                end else if (count_reg >= pea_pkg::CNT_W'(N)) begin
                    res_next.status = pea_pkg::STAT_FULL;
                end else begin
                    cmd_next.op  = pea_pkg::OP_INSERT;
                    cmd_next.idx = has_next ? next_idx : count_reg[pea_pkg::IDX_W-1:0];
                    count_next   = count_reg + pea_pkg::CNT_W'(1);
                    total_next   = total_reg + pea_pkg::PAGE_W'(1);
                end
            end
            pea_pkg::ACT_RESTART: begin
                count_next = '0;
                total_next = '0;
                if (base_reg == '0) begin
                    res_next.status = pea_pkg::STAT_ZERO;
                end else if (pcount_reg != '0) begin
                    cmd_next.op    = pea_pkg::OP_LOAD;
                    cmd_next.start = base_reg;
                    cmd_next.len   = load_len;
                    count_next     = pea_pkg::CNT_W'(1);
                    total_next     = load_len;
                end
            end
            default: begin
                res_next.status = pea_pkg::STAT_OK;
            end
        endcase
        res_next.pages_free = total_next;
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_CMP;
            S_CMP:   state_next = S_DEC;
            S_DEC:   state_next = S_APPLY;
            S_APPLY: if (apply_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
            base_reg    <= pea_pkg::PAGE_W'(1);
            pcount_reg  <= pea_pkg::PAGE_W'(1);
            cmd_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                if (cfg_index) pcount_reg <= cfg_data;
                else           base_reg   <= cfg_data;
            end
            if (state_reg == S_DEC) cmd_reg <= cmd_next;
            if (apply_fire) begin
                count_reg   <= dcount_reg;
                total_reg   <= dtotal_reg;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) item_reg <= s_data;
        if (state_reg == S_DEC) begin
            res_reg    <= res_next;
            dcount_reg <= count_next;
            dtotal_reg <= total_next;
        end
        if (apply_fire) out_reg <= res_reg;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

### hdl/pea_checker.sv
`default_nettype none
module pea_protocol_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire pea_pkg::out_word_t m_data
);

    // A stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Only defined status codes leave the block
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= pea_pkg::STAT_ZERO)
        else $error("undefined status code");

    // A page is granted only on success
    a_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != pea_pkg::STAT_OK |-> m_data.granted_page == '0)
        else $error("page granted on failed action");

    // No result straight after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind page_extent_allocator_unit pea_protocol_checker u_pea_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

### tb/pea_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module pea_checker (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    input  wire logic                       s_ready,
    input  wire pea_pkg::in_word_t          s_data,
    input  wire logic                       m_valid,
    input  wire logic                       m_ready,
    input  wire pea_pkg::out_word_t         m_data,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [pea_pkg::PAGE_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending_words,
    output int                              words_seen,
    output int                              frees_joined,
    output int                              full_hits
);

    // Shadow copy of the free-extent table
    logic [pea_pkg::PAGE_W-1:0] run_start [pea_pkg::MAX_EXTENTS];
    logic [pea_pkg::PAGE_W-1:0] run_len   [pea_pkg::MAX_EXTENTS];
    int                         run_count;
    logic [pea_pkg::PAGE_W-1:0] total_free;
    logic [pea_pkg::PAGE_W-1:0] base_page;
    logic [pea_pkg::PAGE_W-1:0] page_count;

    pea_pkg::out_word_t expected_words [$];

    assign pending_words = expected_words.size();

    // Remove extent at idx, closing the gap
    function automatic void squeeze_out(int idx);
        for (int k = idx; k + 1 < run_count; k++) begin
            run_start[k] = run_start[k + 1];
            run_len[k]   = run_len[k + 1];
        end
        run_count--;
    endfunction

    function automatic pea_pkg::out_word_t apply_action(pea_pkg::in_word_t w);
        pea_pkg::out_word_t         r;
        int                         idx;
        logic [pea_pkg::END_W-1:0]  prev_end;
        logic [pea_pkg::END_W-1:0]  room;
        bit                         has_prev, has_next, join_prev, join_next;
        logic [pea_pkg::PAGE_W-1:0] pg;
        r  = '0;
        pg = w.free_page;
        r.status = pea_pkg::STAT_OK;
        case (w.action)
            pea_pkg::ACT_ALLOC: begin
                if (total_free == '0 || run_count == 0) begin
                    r.status = pea_pkg::STAT_EMPTY;
                end else begin
                    r.granted_page = run_start[0];
                    run_start[0]   = run_start[0] + 1'b1;
                    run_len[0]     = run_len[0] - 1'b1;
                    total_free     = total_free - 1'b1;
                    if (run_len[0] == '0) squeeze_out(0);
                end
            end
            pea_pkg::ACT_FREE: begin
                if (pg == '0) begin
                    r.status = pea_pkg::STAT_ZERO;
                end else begin
                    idx = 0;
                    while (idx < run_count && run_start[idx] < pg) idx++;
                    has_prev = idx > 0;
                    has_next = idx < run_count;
                    prev_end = has_prev ?
                        {1'b0, run_start[idx - 1]} + {1'b0, run_len[idx - 1]} : '0;
                    if (has_prev && prev_end > {1'b0, pg}) begin
                        r.status = pea_pkg::STAT_OVERLAP;
                    end else if (has_next && run_start[idx] == pg) begin
                        r.status = pea_pkg::STAT_OVERLAP;
                    end else begin
                        join_prev = has_prev && prev_end == {1'b0, pg};
                        join_next = has_next &&
                                    {1'b0, pg} + pea_pkg::END_W'(1) == {1'b0, run_start[idx]};
                        if (join_prev || join_next) frees_joined++;
                        if (join_prev && join_next) begin
                            run_len[idx - 1] = run_len[idx - 1] + 1'b1 + run_len[idx];
                            squeeze_out(idx);
                        end else if (join_next) begin
                            run_start[idx] = pg;
                            run_len[idx]   = run_len[idx] + 1'b1;
                        end else if (join_prev) begin
                            run_len[idx - 1] = run_len[idx - 1] + 1'b1;
                        end else if (run_count >= pea_pkg::MAX_EXTENTS) begin
                            r.status = pea_pkg::STAT_FULL;
                            full_hits++;
                        end else begin
                            for (int k = run_count; k > idx; k--) begin
                                run_start[k] = run_start[k - 1];
                                run_len[k]   = run_len[k - 1];
                            end
                            run_start[idx] = pg;
                            run_len[idx]   = pea_pkg::PAGE_W'(1);
                            run_count++;
                        end
                        if (r.status == pea_pkg::STAT_OK) total_free = total_free + 1'b1;
                    end
                end
            end
            pea_pkg::ACT_RESTART: begin
                run_count  = 0;
                total_free = '0;
                if (base_page == '0) begin
                    r.status = pea_pkg::STAT_ZERO;
                end else if (page_count != '0) begin
                    room = pea_pkg::PAGE_SPACE - {1'b0, base_page};
                    run_start[0] = base_page;
                    run_len[0]   = ({1'b0, page_count} > room) ? room[pea_pkg::PAGE_W-1:0]
                                                              : page_count;
                    run_count  = 1;
                    total_free = run_len[0];
                end
            end
            default: ;
        endcase
        r.pages_free = total_free;
        return r;
    endfunction

    // Predict on input words, compare on output words
    always @(posedge aclk) begin
        pea_pkg::out_word_t exp_w;
        int                 errs;
        errs = 0;
        if (!aresetn) begin
            run_count     = 0;
            total_free    = '0;
            base_page     = pea_pkg::PAGE_W'(1);
            page_count    = pea_pkg::PAGE_W'(1);
            fail_count   <= 0;
            words_seen   <= 0;
            frees_joined  = 0;
            full_hits     = 0;
            expected_words.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index) page_count = cfg_data;
                else           base_page  = cfg_data;
            end
            if (m_valid && m_ready) begin
                words_seen <= words_seen + 1;
                if (expected_words.size() == 0) begin
                    $error("unexpected result word %p", m_data);
                    errs++;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (m_data.granted_page !== exp_w.granted_page) begin
                        $error("granted_page expected %h got %h",
                               exp_w.granted_page, m_data.granted_page);
                        errs++;
                    end
                    if (m_data.status !== exp_w.status) begin
                        $error("status expected %0d got %0d", exp_w.status, m_data.status);
                        errs++;
                    end
                    if (m_data.pages_free !== exp_w.pages_free) begin
                        $error("pages_free expected %h got %h",
                               exp_w.pages_free, m_data.pages_free);
                        errs++;
                    end
                end
            end
            if (s_valid && s_ready) expected_words.push_back(apply_action(s_data));
            if (errs != 0) fail_count <= fail_count + errs;
        end
    end
endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;

    localparam int CYCLE_LIMIT = 400000;

    // Action code with no meaning; the block must leave its state alone
    localparam logic [pea_pkg::ACT_W-1:0] ACT_SPARE = 2'd3;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    pea_pkg::in_word_t          s_data = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    pea_pkg::out_word_t         m_data;
    logic                       cfg_we = 1'b0;
    logic                       cfg_index = 1'b0;
    logic [pea_pkg::PAGE_W-1:0] cfg_data = '0;
    int                         fail_count, pending_words, words_seen, frees_joined, full_hits;
    int                         cycle_count = 0;
    int                         burst_left = 0;
    int                         sent_words = 0;

    page_extent_allocator_unit uut (.*);

    pea_checker chk (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver stalls in its own rhythm: phases of free flow and phases of stutter
    always @(negedge aclk) begin
        if (((cycle_count / 300) % 3) == 0) m_ready <= 1'b1;
        else                               m_ready <= ($urandom_range(0, 3) != 0);
    end

    // Valid stays high across a burst; it drops only for a gap or a drain
    task automatic send_word(input logic [pea_pkg::ACT_W-1:0] act,
                             input logic [pea_pkg::PAGE_W-1:0] pg);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= '{action: act, free_page: pg};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        sent_words++;
    endtask

    task automatic write_reg(input logic idx, input logic [pea_pkg::PAGE_W-1:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain_all();
        s_valid <= 1'b0;
        burst_left = 0;
        while (pending_words != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_region(input logic [pea_pkg::PAGE_W-1:0] b,
                              input logic [pea_pkg::PAGE_W-1:0] n);
        drain_all();
        write_reg(1'b0, b);
        write_reg(1'b1, n);
        send_word(pea_pkg::ACT_RESTART, pea_pkg::PAGE_W'($urandom));
    endtask

    // Random phase: a fixed mix of allocates and frees, mostly inside a region
    task automatic churn(input int n, input logic [pea_pkg::PAGE_W-1:0] lo, input int span);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                send_word(pea_pkg::ACT_ALLOC, pea_pkg::PAGE_W'($urandom));
            end else if (r < 92) begin
                send_word(pea_pkg::ACT_FREE,
                          lo + pea_pkg::PAGE_W'($urandom_range(0, span)));
            end else if (r < 95) begin
                send_word(pea_pkg::ACT_FREE, pea_pkg::PAGE_W'($urandom));
            end else if (r < 97) begin
                send_word(ACT_SPARE, pea_pkg::PAGE_W'($urandom));
            end else begin
                send_word(pea_pkg::ACT_FREE, '0);
            end
        end
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed corner cases
        send_word(pea_pkg::ACT_ALLOC, '0);                 // nothing free yet
        send_word(pea_pkg::ACT_RESTART, '0);               // reset region: page 1
        send_word(pea_pkg::ACT_ALLOC, '0);
        send_word(pea_pkg::ACT_ALLOC, '0);                 // empty
        send_word(pea_pkg::ACT_FREE, '0);                  // page zero
        send_word(pea_pkg::ACT_FREE, 20'h00001);
        send_word(pea_pkg::ACT_FREE, 20'h00001);           // double free
        send_word(ACT_SPARE, 20'hFFFFF);
        set_region(20'hFFFF0, 20'hFFFFF);                  // clipped to top page
        send_word(pea_pkg::ACT_FREE, 20'hFFFFF);           // overlap
        send_word(pea_pkg::ACT_FREE, 20'hFFFEF);           // join below start
        send_word(pea_pkg::ACT_FREE, 20'h00005);
        send_word(pea_pkg::ACT_FREE, 20'h00007);
        send_word(pea_pkg::ACT_FREE, 20'h00006);           // join both sides
        send_word(pea_pkg::ACT_ALLOC, '0);
        set_region('0, 20'h00005);                         // base zero
        set_region(20'h00010, '0);                         // count zero
        set_region(20'h00001, 20'hFFFFF);                  // whole space

        // Fill the table with isolated pages until it reports full
        set_region(20'h00100, 20'h00001);
        for (int i = 0; i < 66; i++)
            send_word(pea_pkg::ACT_FREE, 20'h00200 + pea_pkg::PAGE_W'(2 * i));
        send_word(pea_pkg::ACT_FREE, 20'h00300);
        for (int i = 0; i < 20; i++) send_word(pea_pkg::ACT_ALLOC, '0);

        // Randomised phases over a range of region settings
        set_region(20'h00040, 20'd16);
        churn(120, 20'h00030, 48);
        set_region(20'h00800, 20'd64);
        churn(120, 20'h007C0, 200);
        set_region(pea_pkg::PAGE_W'($urandom_range(1, 20'hFFFFF)),
                   pea_pkg::PAGE_W'($urandom_range(1, 20'hFFFFF)));
        churn(100, 20'h00010, 20'hFFFEF);
        set_region(20'hFFFC0, 20'hFFFFF);
        churn(100, 20'hFFF80, 127);
        set_region(20'h00001, 20'd8);
        churn(120, 20'h00001, 40);

        drain_all();
        repeat (20) @(negedge aclk);
        $display("Covered %0d actions, %0d results, %0d coalescing frees, %0d full-table hits",
                 sent_words, words_seen, frees_joined, full_hits);
        if (fail_count == 0) $display("Test completed successfully");
        else                 $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

### page_extent_allocator_unit.f
hdl/pea_pkg.sv
hdl/pea_cell.sv
hdl/page_extent_allocator_unit.sv
hdl/pea_checker.sv
tb/pea_checker.sv
tb/tb.sv
